// ----- src/ms_adpcm_block_decoder_unit_assert.svh -----
// Assertion macros for the MS ADPCM block decoder.
`ifndef MS_ADPCM_BLOCK_DECODER_UNIT_ASSERT_SVH
`define MS_ADPCM_BLOCK_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/msadpcm_pkg.sv -----
// Shared types, constants and coefficient tables of the MS ADPCM block decoder.
package msadpcm_pkg;

    localparam int SMP_W  = 16;
    localparam int COEF_W = 11;
    localparam int NIB_W  = 4;

    localparam logic signed [SMP_W-1:0] DELTA_FLOOR = 16'sd16;
    localparam logic signed [SMP_W-1:0] DELTA_RESET = 16'sd16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ACC   = 2'd1;
    localparam logic [1:0] OP_PRED  = 2'd2;
    localparam logic [1:0] OP_DELTA = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       acc_en;
    } t_mac_ctl;

    function automatic logic signed [COEF_W-1:0] coef_one(input logic [2:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            3'd0:    c = 11'sd256;
            3'd1:    c = 11'sd512;
            3'd2:    c = 11'sd0;
            3'd3:    c = 11'sd192;
            3'd4:    c = 11'sd240;
            3'd5:    c = 11'sd460;
            3'd6:    c = 11'sd392;
            default: c = 11'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_two(input logic [2:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            3'd0:    c = 11'sd0;
            3'd1:    c = -11'sd256;
            3'd2:    c = 11'sd0;
            3'd3:    c = 11'sd64;
            3'd4:    c = 11'sd0;
            3'd5:    c = -11'sd208;
            3'd6:    c = -11'sd232;
            default: c = 11'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] adapt_factor(input logic [NIB_W-1:0] nib);
        logic signed [COEF_W-1:0] f;
        unique case (nib)
            4'd4, 4'd12: f = 11'sd307;
            4'd5, 4'd11: f = 11'sd409;
            4'd6, 4'd10: f = 11'sd512;
            4'd7, 4'd9:  f = 11'sd614;
            4'd8:        f = 11'sd768;
            default:     f = 11'sd230;
        endcase
        return f;
    endfunction

endpackage

// ----- src/msadpcm_mac.sv -----
// Shared multiplier with accumulator and prediction / step-delta post-processing.
module msadpcm_mac (
    input  logic                                      i_clk,
    input  msadpcm_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [msadpcm_pkg::SMP_W-1:0]      i_a,
    input  logic signed [msadpcm_pkg::COEF_W-1:0]     i_b,
    output logic signed [msadpcm_pkg::SMP_W-1:0]      o_pred,
    output logic signed [msadpcm_pkg::SMP_W-1:0]      o_delta
);

    localparam int PROD_W = msadpcm_pkg::SMP_W + msadpcm_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [19:0]       acc_q;
    logic signed [20:0]       pred_sum;
    logic signed [18:0]       dq;
    logic signed [msadpcm_pkg::SMP_W-1:0] d_wrap;

    assign prod = PROD_W'(i_a) * PROD_W'(i_b);

    always_comb begin
        case (i_ctl.op)
            msadpcm_pkg::OP_LOAD: n_acc = ACC_W'(prod);
            msadpcm_pkg::OP_ACC:  n_acc = r_acc + ACC_W'(prod);
            default:              n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        acc_q    = 20'(r_acc >>> 8) + ((r_acc[ACC_W-1] && (|r_acc[7:0])) ? 20'sd1 : 20'sd0);
        pred_sum = 21'(acc_q) + 21'(prod);
        if (pred_sum > 21'sd32767) begin
            o_pred = 16'sh7FFF;
        end else if (pred_sum < -21'sd32768) begin
            o_pred = 16'sh8000;
        end else begin
            o_pred = pred_sum[15:0];
        end
    end

    always_comb begin
        dq     = 19'(prod >>> 8) + ((prod[PROD_W-1] && (|prod[7:0])) ? 19'sd1 : 19'sd0);
        d_wrap = dq[15:0];
        if (d_wrap < msadpcm_pkg::DELTA_FLOOR) begin
            o_delta = msadpcm_pkg::DELTA_FLOOR;
        end else begin
            o_delta = d_wrap;
        end
    end

endmodule

// ----- src/ms_adpcm_block_decoder_unit.sv -----
// Top level of the MS ADPCM block decoder: header parsing, nibble sequencer, result queue.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_data_byte, i_block_end
//  output   out        o_valid / i_stall   o_pcm_sample, o_pair_last, o_block_last,
//                                          o_bad_predictor
//
// Header bytes do not stall the input, but the last stalls it while two results are pushed.
// A data byte is accepted, then each nibble, low first, runs four multiplier steps (S_P1 to S_P4).
// The single shared 16x11 multiplier serves every step; input stalls while it runs.
// Synchronous active-low reset; a two-entry result queue absorbs output stalls.
module ms_adpcm_block_decoder_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [7:0]                            i_data_byte,
    input  logic                                  i_block_end,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [msadpcm_pkg::SMP_W-1:0]  o_pcm_sample,
    output logic                                  o_pair_last,
    output logic                                  o_block_last,
    output logic                                  o_bad_predictor
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EMIT_H0 = 3'd1;
    localparam logic [2:0] S_EMIT_H1 = 3'd2;
    localparam logic [2:0] S_P1      = 3'd3;
    localparam logic [2:0] S_P2      = 3'd4;
    localparam logic [2:0] S_P3      = 3'd5;
    localparam logic [2:0] S_P4      = 3'd6;

    localparam logic [2:0] HPOS_DATA = 3'd7;

    typedef struct packed {
        logic signed [msadpcm_pkg::SMP_W-1:0] sample;
        logic                                 pl;
        logic                                 bl;
        logic                                 bad;
    } t_res;

    logic [2:0] r_state, n_state;
    logic [2:0] r_hpos;
    logic [2:0] r_pidx;
    logic       r_pinv;
    logic [7:0] r_lo;
    logic signed [msadpcm_pkg::SMP_W-1:0] r_delta;
    logic signed [msadpcm_pkg::SMP_W-1:0] r_newer;
    logic signed [msadpcm_pkg::SMP_W-1:0] r_older;
    logic signed [msadpcm_pkg::SMP_W-1:0] r_pred;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_sel;

    t_res       r_fq [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic       in_acc, pop, push, push_ok;
    t_res       push_res;
    logic [msadpcm_pkg::NIB_W-1:0] nib;
    logic [15:0] word;

    msadpcm_pkg::t_mac_ctl mac_ctl;
    logic signed [msadpcm_pkg::SMP_W-1:0]  mac_a;
    logic signed [msadpcm_pkg::COEF_W-1:0] mac_b;
    logic signed [msadpcm_pkg::SMP_W-1:0]  mac_pred;
    logic signed [msadpcm_pkg::SMP_W-1:0]  mac_delta;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign push_ok = (r_cnt != 2'd2);
    assign word    = {i_data_byte, r_lo};
    assign nib     = r_sel ? r_byte[7:4] : r_byte[3:0];

    assign o_pcm_sample    = r_fq[r_rp].sample;
    assign o_pair_last     = r_fq[r_rp].pl;
    assign o_block_last    = r_fq[r_rp].bl;
    assign o_bad_predictor = r_fq[r_rp].bad;

    always_comb begin
        mac_ctl.op     = msadpcm_pkg::OP_PRED;
        mac_ctl.acc_en = 1'b0;
        mac_a          = r_delta;
        mac_b          = 11'(signed'(nib));
        unique case (r_state)
            S_P1: begin
                mac_ctl.op     = msadpcm_pkg::OP_LOAD;
                mac_ctl.acc_en = 1'b1;
                mac_a          = r_newer;
                mac_b          = r_pinv ? '0 : msadpcm_pkg::coef_one(r_pidx);
            end
            S_P2: begin
                mac_ctl.op     = msadpcm_pkg::OP_ACC;
                mac_ctl.acc_en = 1'b1;
                mac_a          = r_older;
                mac_b          = r_pinv ? '0 : msadpcm_pkg::coef_two(r_pidx);
            end
            S_P4: begin
                mac_ctl.op = msadpcm_pkg::OP_DELTA;
                mac_b      = msadpcm_pkg::adapt_factor(nib);
            end
            default: begin
            end
        endcase
    end

    msadpcm_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_pred  (mac_pred),
        .o_delta (mac_delta)
    );

    always_comb begin
        n_state      = r_state;
        push         = 1'b0;
        push_res.sample = r_pred;
        push_res.pl  = r_sel;
        push_res.bl  = r_sel && r_end;
        push_res.bad = r_pinv;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && r_hpos == 3'd6) begin
                    n_state = S_EMIT_H0;
                end else if (in_acc && r_hpos == HPOS_DATA) begin
                    n_state = S_P1;
                end
            end
            S_EMIT_H0: begin
                push            = push_ok;
                push_res.sample = r_older;
                push_res.pl     = 1'b0;
                push_res.bl     = 1'b0;
                if (push_ok) begin
                    n_state = S_EMIT_H1;
                end
            end
            S_EMIT_H1: begin
                push            = push_ok;
                push_res.sample = r_newer;
                push_res.pl     = 1'b1;
                push_res.bl     = r_end;
                if (push_ok) begin
                    n_state = S_IDLE;
                end
            end
            S_P1: n_state = S_P2;
            S_P2: n_state = S_P3;
            S_P3: n_state = S_P4;
            S_P4: begin
                push = push_ok;
                if (push_ok) begin
                    n_state = r_sel ? S_IDLE : S_P1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hpos  <= 3'd0;
            r_pidx  <= 3'd0;
            r_pinv  <= 1'b0;
            r_lo    <= 8'd0;
            r_delta <= msadpcm_pkg::DELTA_RESET;
            r_newer <= '0;
            r_older <= '0;
            r_cnt   <= 2'd0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                unique case (r_hpos)
                    3'd0: begin
                        r_pidx <= i_data_byte[2:0];
                        r_pinv <= (i_data_byte >= 8'd7);
                    end
                    3'd1, 3'd3, 3'd5: r_lo    <= i_data_byte;
                    3'd2:             r_delta <= word;
                    3'd4:             r_older <= word;
                    3'd6:             r_newer <= word;
                    default: begin
                    end
                endcase
                if (i_block_end) begin
                    r_hpos <= 3'd0;
                end else if (r_hpos != HPOS_DATA) begin
                    r_hpos <= r_hpos + 3'd1;
                end
            end
            if (r_state == S_P4 && push_ok) begin
                r_delta <= mac_delta;
                r_older <= r_newer;
                r_newer <= r_pred;
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_data_byte;
            r_end  <= i_block_end;
            r_sel  <= 1'b0;
        end else if (r_state == S_P4 && push_ok) begin
            r_sel <= ~r_sel;
        end
        if (r_state == S_P3) begin
            r_pred <= mac_pred;
        end
        if (push) begin
            r_fq[r_wp] <= push_res;
        end
    end

`include "ms_adpcm_block_decoder_unit_assert.svh"

    `MSA_ASSERT_NEXT(a_data_starts_calc, in_acc && r_hpos == HPOS_DATA, r_state == S_P1, "data byte did not start nibble decode")
    `MSA_ASSERT_NOW(a_no_push_when_full, push, r_cnt != 2'd2, "result pushed into full queue")
    `MSA_ASSERT_NEXT(a_delta_floor, r_state == S_P4 && push_ok, r_delta >= msadpcm_pkg::DELTA_FLOOR, "adapted step delta below floor")

endmodule
